// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg: shared definitions for the generational handle allocator
// Slot pool sizing, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned LINK_W     = SLOT_W + 1;
  localparam int unsigned COUNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int unsigned OP_W       = 3;
  localparam int unsigned HIDX_W     = 16;
  localparam int unsigned GEN_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN   = 3'd0,
    OP_COMMIT  = 3'd1,
    OP_ALLOC   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CHECK   = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;    // latch the operands and launch the memory reads
    logic rd_head;    // read address comes from the free head
    logic emit;       // register one result beat
    logic ok;         // result flag
    logic set_phase;  // open the update phase
    logic clr_phase;  // close the update phase
    logic pop;        // take the free head for an allocation
    logic push;       // retire the addressed slot onto the free list
  } cmd_t;

  typedef struct packed {
    logic phase_open;
    logic list_empty;
    logic handle_valid;
  } status_t;

endpackage : gha_pkg

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot pool with generation-tagged handles
// Top level joining the operation sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; each command
// first reads the slot tables, then checks and updates them (writing back
// on a release), so busy_o is high in the execute state that follows each accepted
// beat and no new command is taken until the previous one has ended. Each
// command yields exactly one result beat, shown on the result ports for one
// cycle with result_valid_o high, in the cycle after the execute cycle; the
// receiver cannot stall, so it must take the beat in that cycle. Begin opens
// an update phase, commit closes it; allocate and release only succeed
// inside a phase. Allocation pops the most recently released slot first and
// returns its index and generation; release bumps the slot generation so that
// stale handles then fail the check operation. Every result carries the live
// count after the command. The pool is ready right after reset: no clearing
// pass is needed, since untouched table entries read as their reset values.
module generational_handle_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [gha_pkg::OP_W-1:0]    op_i,
  input  logic [gha_pkg::HIDX_W-1:0]  handle_index_i,
  input  logic [gha_pkg::GEN_W-1:0]   handle_generation_i,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic [gha_pkg::SLOT_W-1:0]  slot_index_o,
  output logic [gha_pkg::GEN_W-1:0]   slot_generation_o,
  output logic [gha_pkg::COUNT_W-1:0] live_count_o
);
  import gha_pkg::*;

  // Commands from the sequencer and flags back from the datapath.
  cmd_t    cmd;
  status_t status;

  gha_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  gha_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .status_o            (status),
    .result_valid_o      (result_valid_o),
    .ok_o                (ok_o),
    .slot_index_o        (slot_index_o),
    .slot_generation_o   (slot_generation_o),
    .live_count_o        (live_count_o)
  );

endmodule : generational_handle_allocator

// ===== rtl/gha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gha_ctrl: operation sequencer
// Two-state machine that takes one command, then decides in the execute
// cycle which datapath update applies and what the result flag is.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [gha_pkg::OP_W-1:0] op_i,
  input  gha_pkg::status_t      status_i,
  output gha_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);
  import gha_pkg::*;

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.capture) begin
      op_q <= op_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.rd_head = (op_i == OP_ALLOC);
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
        case (op_q)
          OP_BEGIN: begin
            cmd_o.set_phase = !status_i.phase_open;
            cmd_o.ok        = !status_i.phase_open;
          end
          OP_COMMIT: begin
            cmd_o.clr_phase = 1'b1;
            cmd_o.ok        = 1'b1;
          end
          OP_ALLOC: begin
            cmd_o.pop = status_i.phase_open && !status_i.list_empty;
            cmd_o.ok  = status_i.phase_open && !status_i.list_empty;
          end
          OP_RELEASE: begin
            cmd_o.push = status_i.phase_open && status_i.handle_valid;
            cmd_o.ok   = status_i.phase_open && status_i.handle_valid;
          end
          OP_CHECK: begin
            cmd_o.ok = status_i.handle_valid;
          end
          default: begin
            cmd_o.ok = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q == ST_EXEC);

`ifndef SYNTH
  // Every accepted command enters execute and leaves it on the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not enter execute");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("execute lasted more than one cycle");
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit == busy_o)
    else $error("result issued outside execute");
`endif

endmodule : gha_ctrl

// ===== rtl/gha_dpath.sv =====
// ----------------------------------------------------------------------------
// gha_dpath: slot tables, free list and result registers
// Holds the link and generation memories with a shared per-entry written bit,
// the active marks, the free head, the live count and the phase flag.
// ----------------------------------------------------------------------------
module gha_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gha_pkg::cmd_t               cmd_i,
  input  logic [gha_pkg::HIDX_W-1:0]  handle_index_i,
  input  logic [gha_pkg::GEN_W-1:0]   handle_generation_i,
  output gha_pkg::status_t            status_o,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic [gha_pkg::SLOT_W-1:0]  slot_index_o,
  output logic [gha_pkg::GEN_W-1:0]   slot_generation_o,
  output logic [gha_pkg::COUNT_W-1:0] live_count_o
);
  import gha_pkg::*;

  logic [LINK_W-1:0]     link_mem [SLOT_COUNT];
  logic [GEN_W-1:0]      gen_mem  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written_q;
  logic [SLOT_COUNT-1:0] active_q;

  logic [LINK_W-1:0]  free_head_q, free_head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               phase_q;

  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  addr_q;
  logic [LINK_W-1:0]  link_rd_q;
  logic [GEN_W-1:0]   gen_rd_q;
  logic [GEN_W-1:0]   hgen_q;
  logic               in_range_q;

  logic [LINK_W-1:0]  link_eff;
  logic [GEN_W-1:0]   gen_eff;

  logic               valid_q;
  logic               ok_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [GEN_W-1:0]   gen_out_q;
  logic [COUNT_W-1:0] live_q;

  assign rd_addr = cmd_i.rd_head ? free_head_q[SLOT_W-1:0] : handle_index_i[SLOT_W-1:0];

  // Registered reads and operand capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      link_rd_q  <= link_mem[rd_addr];
      gen_rd_q   <= gen_mem[rd_addr];
      addr_q     <= rd_addr;
      hgen_q     <= handle_generation_i;
      in_range_q <= (32'(handle_index_i) < SLOT_COUNT);
    end
  end

  // An entry that was never written holds its reset value. Both tables are
  // always written together, so one written bit covers the pair.
  assign link_eff = written_q[addr_q] ? link_rd_q : LINK_W'(addr_q) + LINK_W'(1);
  assign gen_eff  = written_q[addr_q] ? gen_rd_q : GEN_W'(1);

  assign status_o.phase_open   = phase_q;
  assign status_o.list_empty   = (free_head_q == LINK_W'(SLOT_COUNT));
  assign status_o.handle_valid = in_range_q && active_q[addr_q] && (gen_eff == hgen_q);

  always_comb begin
    free_head_d = free_head_q;
    count_d     = count_q;
    if (cmd_i.pop) begin
      free_head_d = link_eff;
      count_d     = count_q + COUNT_W'(1);
    end else if (cmd_i.push) begin
      free_head_d = LINK_W'(addr_q);
      if (count_q != '0) begin
        count_d = count_q - COUNT_W'(1);
      end
    end
  end

  // Memory writes happen only on a release.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      link_mem[addr_q] <= free_head_q;
      gen_mem[addr_q]  <= gen_eff + GEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      active_q    <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      phase_q     <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      valid_q     <= cmd_i.emit;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      if (cmd_i.set_phase) begin
        phase_q <= 1'b1;
      end else if (cmd_i.clr_phase) begin
        phase_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        active_q[addr_q] <= 1'b1;
      end else if (cmd_i.push) begin
        active_q[addr_q]  <= 1'b0;
        written_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ok_q      <= cmd_i.ok;
      idx_q     <= cmd_i.pop ? addr_q : '0;
      gen_out_q <= cmd_i.pop ? gen_eff : '0;
      live_q    <= count_d;
    end
  end

  assign result_valid_o    = valid_q;
  assign ok_o              = ok_q;
  assign slot_index_o      = idx_q;
  assign slot_generation_o = gen_out_q;
  assign live_count_o      = live_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(SLOT_COUNT))
    else $error("live count above capacity");
  a_pop_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.pop && cmd_i.push))
    else $error("allocate and release in the same cycle");
  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == LINK_W'(SLOT_COUNT)) == (count_q == COUNT_W'(SLOT_COUNT)))
    else $error("free list and live count disagree");
`endif

endmodule : gha_dpath

// ===== dv/generational_handle_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator_tb: self-checking bench for the slot allocator
// Drives begin, commit, allocate, release and check commands and undefined codes through the
// start/busy handshake. A scoreboard keeps its own copy of the slot pool,
// works out the result beat of every accepted command and compares each
// result beat against it field by field.
// ----------------------------------------------------------------------------
module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned ITEM_GOAL    = 1900;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Operation codes that the block does not define; they still yield a beat.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: a private model of the slot pool plus the queue of result
  // beats still owed by the block.
  // --------------------------------------------------------------------------
  class slot_pool_scoreboard;
    typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot;
      logic [GEN_W-1:0]   gen;
      logic [COUNT_W-1:0] live;
    } outcome_t;

    bit [LINK_W-1:0]  link_next [SLOT_COUNT];
    bit [GEN_W-1:0]   slot_gen  [SLOT_COUNT];
    bit               slot_live [SLOT_COUNT];
    bit [LINK_W-1:0]  free_head;
    bit [COUNT_W-1:0] live_total;
    bit               phase_open;
    outcome_t         outcomes_due [$];
    int unsigned      mismatches;

    function new();
      for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
        link_next[i] = LINK_W'(i + 1);
        slot_gen[i]  = GEN_W'(1);
        slot_live[i] = 1'b0;
      end
      free_head  = '0;
      live_total = '0;
      phase_open = 1'b0;
      mismatches = 0;
    endfunction

    // A handle is live only if its index is in the pool, the slot is taken
    // and the generation tag matches the slot's current one.
    function bit handle_valid(logic [HIDX_W-1:0] idx, logic [GEN_W-1:0] gen);
      if (idx >= SLOT_COUNT) return 1'b0;
      return slot_live[idx] && slot_gen[idx] == gen;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [HIDX_W-1:0] idx,
                               logic [GEN_W-1:0] gen);
      outcome_t    o;
      int unsigned s;
      o = '0;
      case (op)
        OP_BEGIN: begin
          if (!phase_open) begin
            phase_open = 1'b1;
            o.ok       = 1'b1;
          end
        end
        OP_COMMIT: begin
          phase_open = 1'b0;
          o.ok       = 1'b1;
        end
        OP_ALLOC: begin
          if (phase_open && free_head < SLOT_COUNT) begin
            s            = free_head;
            free_head    = link_next[s];
            slot_live[s] = 1'b1;
            live_total   = live_total + 1'b1;
            o.ok         = 1'b1;
            o.slot       = s[SLOT_W-1:0];
            o.gen        = slot_gen[s];
          end
        end
        OP_RELEASE: begin
          if (phase_open && handle_valid(idx, gen)) begin
            s            = idx;
            slot_live[s] = 1'b0;
            slot_gen[s]  = slot_gen[s] + 1'b1;  // wraps from all ones to zero
            link_next[s] = free_head;
            free_head    = s[LINK_W-1:0];
            if (live_total > 0) live_total = live_total - 1'b1;
            o.ok         = 1'b1;
          end
        end
        OP_CHECK: o.ok = handle_valid(idx, gen);
        default: ;
      endcase
      o.live = live_total;
      outcomes_due.push_back(o);
    endfunction

    function void check_result(logic ok, logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen,
                               logic [COUNT_W-1:0] live);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing outstanding: ok=%0d slot=%0d gen=%h live=%0d",
                   $realtime, ok, slot, gen, live);
        return;
      end
      want = outcomes_due.pop_front();
      if (ok !== want.ok || slot !== want.slot || gen !== want.gen || live !== want.live) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"[%0t] result mismatch: expected ok=%0d slot=%0d gen=%h live=%0d,",
                    " got ok=%0d slot=%0d gen=%h live=%0d"},
                   $realtime, want.ok, want.slot, want.gen, want.live, ok, slot, gen, live);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input has a known value from
  // time zero.
  // --------------------------------------------------------------------------
  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                start_i             = 1'b0;
  logic [OP_W-1:0]     op_i                = OP_CHECK;
  logic [HIDX_W-1:0]   handle_index_i      = '0;
  logic [GEN_W-1:0]    handle_generation_i = '0;
  logic                busy_o;
  logic                result_valid_o;
  logic                ok_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [GEN_W-1:0]    slot_generation_o;
  logic [COUNT_W-1:0]  live_count_o;

  slot_pool_scoreboard pool;
  int unsigned         items_sent = 0;
  int unsigned         cycles     = 0;
  int unsigned         idle_by_phase [3] = '{0, 83, 6};

  always #HALF_PERIOD clk_i = ~clk_i;

  generational_handle_allocator DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .op_i                (op_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .result_valid_o      (result_valid_o),
    .ok_o                (ok_o),
    .slot_index_o        (slot_index_o),
    .slot_generation_o   (slot_generation_o),
    .live_count_o        (live_count_o)
  );

  // Outputs are sampled on the falling edge, half a cycle away from any
  // change, so nothing depends on the order of events at the rising edge.
  // A result beat shown in this cycle is taken at the coming rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o)
      pool.check_result(ok_o, slot_index_o, slot_generation_o, live_count_o);
  end

  // Watchdog. The slowest correct run is far below this limit, even with the
  // sender idle most of the time.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Command driver. The idle pattern follows the number of commands sent so
  // far, so the run goes through stretches with no gaps, with the sender idle
  // most of the time, and with rare gaps. A gap lowers start at the edge that
  // takes the previous beat; without a gap the next beat is put on the same
  // edge, so start stays high and gets only one assignment per edge.
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [OP_W-1:0] op, input logic [HIDX_W-1:0] idx,
                              input logic [GEN_W-1:0] gen);
    int unsigned idle_pct;
    idle_pct = idle_by_phase[(items_sent / 160) % 3];
    while ($urandom_range(99) < idle_pct) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    start_i             <= 1'b1;
    op_i                <= op;
    handle_index_i      <= idx;
    handle_generation_i <= gen;
    // The beat is taken at the first rising edge that sees busy low.
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    pool.note_command(op, idx, gen);
    if (op <= OP_CHECK) items_sent++;
  endtask

  // Points a handle at a taken slot, searching from a random place. With an
  // empty pool it falls back to a free slot, which makes the handle invalid.
  function automatic void aim_at_live_slot(output logic [HIDX_W-1:0] idx,
                                           output logic [GEN_W-1:0] gen);
    int unsigned first;
    int unsigned s;
    first = $urandom_range(SLOT_COUNT - 1);
    idx   = HIDX_W'(first);
    gen   = pool.slot_gen[first];
    for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
      s = (first + k) % SLOT_COUNT;
      if (pool.slot_live[s]) begin
        idx = HIDX_W'(s);
        gen = pool.slot_gen[s];
        break;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic. Most of it is well-formed update phases (begin, a burst
  // of allocate, release and check, commit) whose content swings the pool
  // between full and nearly empty: a filling stretch favors allocation until
  // the free list runs dry, so allocations then fail on the empty list, and a
  // draining stretch favors releasing live handles. Mixed in are stale and
  // out-of-range handles, stray begins and commits, undefined codes and
  // bursts that run with the phase closed.
  // --------------------------------------------------------------------------
  task automatic run_random(input int unsigned item_goal);
    bit                filling;
    int unsigned       alloc_pct;
    int unsigned       release_pct;
    int unsigned       r;
    int unsigned       s;
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
    filling = 1'b1;
    while (items_sent < item_goal) begin
      if (filling && pool.free_head == SLOT_COUNT) filling = 1'b0;
      else if (!filling && pool.live_total < 8) filling = 1'b1;
      alloc_pct   = filling ? 75 : 10;
      release_pct = filling ? 5 : 60;

      if ($urandom_range(9) != 0) send_command(OP_BEGIN, HIDX_W'($urandom), $urandom);
      repeat ($urandom_range(1, 40)) begin
        r   = $urandom_range(99);
        idx = HIDX_W'($urandom);
        gen = $urandom;
        s   = $urandom_range(SLOT_COUNT - 1);
        if (r < alloc_pct) begin
          send_command(OP_ALLOC, idx, gen);
        end else if (r < alloc_pct + release_pct) begin
          aim_at_live_slot(idx, gen);
          send_command(OP_RELEASE, idx, gen);
        end else begin
          case ($urandom_range(5))
            0, 1: begin
              aim_at_live_slot(idx, gen);
              send_command(OP_CHECK, idx, gen);
            end
            2: begin
              // Previous generation of a slot: a retired handle.
              idx = HIDX_W'(s);
              gen = pool.slot_gen[s] - 1'b1;
              send_command(OP_CHECK, idx, gen);
            end
            3: begin
              // Current or previous generation; catches double releases.
              idx = HIDX_W'(s);
              gen = pool.slot_gen[s] - $urandom_range(1);
              send_command(OP_RELEASE, idx, gen);
            end
            4: send_command(OP_W'($urandom_range(OP_LAST_UNUSED)), idx, gen);
            default: begin
              idx = HIDX_W'($urandom_range(SLOT_COUNT, 16'hFFFF));
              send_command($urandom_range(1) ? OP_CHECK : OP_RELEASE, idx, gen);
            end
          endcase
        end
      end
      send_command(OP_COMMIT, HIDX_W'($urandom), $urandom);
      if ($urandom_range(9) == 0) send_command(OP_COMMIT, HIDX_W'($urandom), $urandom);
    end
  endtask

  initial begin
    pool = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: everything outside a phase first, then a phase that
    // walks through the failure cases of each operation.
    send_command(OP_CHECK, 16'd0, 32'd1);            // never allocated
    send_command(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF); // phase closed
    send_command(OP_RELEASE, 16'd0, 32'd1);          // phase closed
    send_command(OP_COMMIT, 16'd0, 32'd0);           // commit while closed
    send_command(OP_BEGIN, 16'd0, 32'd0);
    send_command(OP_BEGIN, 16'hFFFF, 32'hFFFF_FFFF); // begin while open
    send_command(OP_ALLOC, 16'd0, 32'd0);            // slot 0
    send_command(OP_ALLOC, 16'd0, 32'd0);            // slot 1
    send_command(OP_CHECK, 16'd0, 32'd1);            // valid handle
    send_command(OP_CHECK, 16'd0, 32'd2);            // wrong generation
    send_command(OP_CHECK, 16'hFFFF, 32'd1);         // index far out of range
    send_command(OP_CHECK, HIDX_W'(SLOT_COUNT), 32'd1);  // first index past the pool
    send_command(OP_RELEASE, 16'd1, 32'hFFFF_FFFF);  // invalid handle
    send_command(OP_RELEASE, 16'd1, 32'd1);
    send_command(OP_CHECK, 16'd1, 32'd1);            // retired handle
    send_command(OP_ALLOC, 16'd0, 32'd0);            // slot 1 again, next generation
    send_command(OP_RELEASE, 16'd0, 32'd1);
    for (int unsigned code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++)
      send_command(OP_W'(code), 16'hFFFF, 32'hFFFF_FFFF);
    send_command(OP_COMMIT, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(OP_RELEASE, 16'd1, 32'd2);          // phase closed, handle valid
    send_command(OP_CHECK, 16'd1, 32'd2);            // checks work outside a phase
    send_command(OP_CHECK, 16'd0, 32'd0);            // generation zero

    run_random(ITEM_GOAL);

    // The last beat is taken at this edge.
    @(posedge clk_i);
    start_i <= 1'b0;

    while (pool.outcomes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pool.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gha_pkg.sv
rtl/gha_ctrl.sv
rtl/gha_dpath.sv
rtl/generational_handle_allocator.sv
dv/generational_handle_allocator_tb.sv
